// ----- design/lsv_pkg.sv -----
package lsv_pkg;

	typedef enum logic [1:0] {
		CMD_KEY    = 2'd0,
		CMD_DIGEST = 2'd1,
		CMD_SIG    = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	localparam int NUM_ELEMENTS = 256;
	localparam int HASH_BYTES   = 32;
	localparam int KEY_DEPTH    = 2 * NUM_ELEMENTS * 4;
	localparam int KEY_AW       = $clog2(KEY_DEPTH);
	localparam logic [7:0] LAST_ELEMENT = 8'(NUM_ELEMENTS - 1);

	// Hash job handed from the front end to the hash engine
	typedef struct packed {
		logic [255:0] msg;
		logic [7:0]   elem;
		logic         bit_sel;
	} job_t;

	typedef enum logic [1:0] {
		HS_IDLE,
		HS_ROUND,
		HS_KEY,
		HS_DONE
	} hash_state_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};
		return k[i];
	endfunction

	localparam logic [255:0] H_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- design/lamport_signature_verify_top.sv -----
// Lamport one-time signature verifier over SHA-256.
// Slave channel s_axis_*: tuser = command, tdata = {pad, data_word, word_index,
// element_index, key_half}. Commands load public-key words into a 2048 x 64
// memory, load the four digest words, or stream signature words.
// Word 3 of a signature element queues a hash job. The engine starts the job,
// runs the SHA-256 rounds, reads and compares the four key words, and then
// finishes, one element at a time on the single shared round unit. Digest
// loads and words 0..2 are accepted without waiting; key loads wait while
// any queued element still has to read the key, so the key seen by an
// element is the one loaded before its word 3.
// A two-entry job queue lets the front keep accepting while the engine works.
// Master channel m_axis_*: one transaction after element 255, tdata =
// {pad, first_mismatch, verdict}; tvalid sits in an output register.
// If the receiver stalls, the engine holds the next final element until the
// result is taken; the queue then fills and s_axis_tready drops for word 3 and
// key loads.
// Reset clears control, the queue, and the running match state; key and
// digest stores are undefined until written.
module lamport_signature_verify_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// bits: 0 key_half, 8:1 element_index, 10:9 word_index, 74:11 data_word
	input  logic [79:0] s_axis_tdata,
	// bits: 1:0 command
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// bits: 0 verdict, 8:1 first_mismatch
	output logic [15:0] m_axis_tdata
);
	import lsv_pkg::*;

	logic key_we;
	logic [KEY_AW-1:0] key_waddr;
	logic [63:0] key_wdata;
	logic fj_valid, fj_ready, hj_valid, hj_ready;
	logic busy;
	job_t fj, hj;
	logic verdict;
	logic [7:0] idx;

	lsv_front u_front (
		.clk,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.command(s_axis_tuser), .key_half(s_axis_tdata[0]),
		.element_index(s_axis_tdata[8:1]), .word_index(s_axis_tdata[10:9]),
		.data_word(s_axis_tdata[74:11]), .busy,
		.key_we, .key_waddr, .key_wdata,
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	lsv_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
		.rd_valid(hj_valid), .rd_ready(hj_ready), .rd_data(hj)
	);

	lsv_hash u_hash (
		.clk, .arst_n,
		.key_we(key_we && s_axis_tready), .key_waddr, .key_wdata,
		.job_valid(hj_valid), .job_ready(hj_ready), .job(hj), .busy,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.res_verdict(verdict), .res_index(idx)
	);

	assign m_axis_tdata = {7'd0, idx, verdict};
endmodule

// ----- design/lsv_front.sv -----
// Front end: decode commands, hold the digest and element words, issue hash jobs
module lsv_front (
	input  logic               clk,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic               key_half,
	input  logic [7:0]         element_index,
	input  logic [1:0]         word_index,
	input  logic [63:0]        data_word,
	input  logic               busy,
	output logic               key_we,
	output logic [lsv_pkg::KEY_AW-1:0] key_waddr,
	output logic [63:0]        key_wdata,
	output logic               job_valid,
	input  logic               job_ready,
	output lsv_pkg::job_t      job
);
	import lsv_pkg::*;

	logic [63:0] digest_q [4];
	logic [63:0] words_q [3];
	logic        is_job;
	logic        is_key;
	logic [63:0] dword;

	// Hold key writes until every queued element has read its key words
	assign is_job   = (cmd_t'(command) == CMD_SIG) && (word_index == 2'd3);
	assign is_key   = cmd_t'(command) == CMD_KEY;
	assign in_ready = is_job ? job_ready : !(is_key && busy);
	assign job_valid = in_valid && is_job;

	// Select digest bit for this element
	assign dword       = digest_q[element_index[7:6]];
	assign job.bit_sel = dword[6'd63 - element_index[5:0]];
	assign job.elem    = element_index;
	assign job.msg     = {words_q[0], words_q[1], words_q[2], data_word};

	assign key_we    = in_valid && is_key;
	assign key_waddr = {key_half, element_index, word_index};
	assign key_wdata = data_word;

	// Hold digest and buffered element words
	always_ff @(posedge clk) begin
		if (in_valid && cmd_t'(command) == CMD_DIGEST) begin
			digest_q[word_index] <= data_word;
		end
		if (in_valid && cmd_t'(command) == CMD_SIG && word_index != 2'd3) begin
			words_q[word_index] <= data_word;
		end
	end
endmodule

// ----- design/lsv_queue.sv -----
// Two-entry job queue between front end and hash engine
module lsv_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  lsv_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output lsv_pkg::job_t rd_data
);
	import lsv_pkg::*;

	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ----- design/lsv_hash.sv -----
// Back end: SHA-256 rounds, public-key compare, verdict tracking
module lsv_hash (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               key_we,
	input  logic [lsv_pkg::KEY_AW-1:0] key_waddr,
	input  logic [63:0]        key_wdata,
	input  logic               job_valid,
	output logic               job_ready,
	input  lsv_pkg::job_t      job,
	output logic               busy,
	output logic               res_valid,
	input  logic               res_ready,
	output logic               res_verdict,
	output logic [7:0]         res_index
);
	import lsv_pkg::*;

	logic [63:0] key_mem [KEY_DEPTH];
	logic [63:0] key_rdata_q;
	logic [KEY_AW-1:0] key_raddr;

	hash_state_t state_q, state_d;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [5:0]  rnd_q;
	logic [2:0]  kw_q;
	logic [7:0]  elem_q;
	logic        bit_q;
	logic        all_q;
	logic [7:0]  mis_q;
	logic [255:0] hash_q;
	logic        out_valid_q;
	logic        out_verdict_q;
	logic [7:0]  out_index_q;

	logic        start, rnd_last, fin;
	logic [31:0] s0, s1, wnew, t1, t2, ch, maj, e, a;
	logic [255:0] hv;

	// Key memory: one write port, one registered read port
	assign key_raddr = {bit_q, elem_q, kw_q[1:0]};
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_waddr] <= key_wdata;
		end
		key_rdata_q <= key_mem[key_raddr];
	end

	// Key reads pending while a job is queued, hashing or reading its key words
	assign busy = job_valid || (state_q inside {HS_ROUND, HS_KEY});

	// Round logic
	assign e   = v_q[4];
	assign a   = v_q[0];
	assign ch  = (e & v_q[5]) ^ (~e & v_q[6]);
	assign maj = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch
		+ round_k(rnd_q) + w_q[0];
	assign t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + maj;
	assign s0  = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1  = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wnew = w_q[0] + s0 + w_q[9] + s1;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			hv[255 - 32*i -: 32] = H_INIT[255 - 32*i -: 32] + v_q[i];
		end
	end

	assign rnd_last = rnd_q == 6'd63;

	// Next state and control
	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		start     = 1'b0;
		fin       = 1'b0;
		case (state_q)
			HS_IDLE: begin
				job_ready = 1'b1;
				start = job_valid;
				if (job_valid) state_d = HS_ROUND;
			end
			HS_ROUND: begin
				if (rnd_last) state_d = HS_KEY;
			end
			HS_KEY: begin
				if (kw_q == 3'd4) state_d = HS_DONE;
			end
			HS_DONE: begin
				if (elem_q != LAST_ELEMENT || !out_valid_q || res_ready) begin
					fin = 1'b1;
					state_d = HS_IDLE;
				end
			end
			default: state_d = HS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hash datapath
	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 8; i++) begin
				w_q[i] <= job.msg[255 - 32*i -: 32];
				v_q[i] <= H_INIT[255 - 32*i -: 32];
			end
			w_q[8] <= 32'h80000000;
			for (int i = 9; i < 15; i++) w_q[i] <= 32'd0;
			w_q[15] <= 32'(HASH_BYTES * 8);
			rnd_q  <= 6'd0;
			elem_q <= job.elem;
			bit_q  <= job.bit_sel;
		end else if (state_q == HS_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
			for (int i = 1; i < 8; i++) begin
				if (i != 4) v_q[i] <= v_q[i-1];
			end
			v_q[0] <= t1 + t2;
			v_q[4] <= v_q[3] + t1;
			rnd_q  <= rnd_q + 6'd1;
		end
		// Capture the digest once all 64 rounds have landed
		if (state_q == HS_KEY && kw_q == 3'd0) hash_q <= hv;
	end

	// Key read address: one word per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_q <= 3'd0;
		end else if (state_q == HS_ROUND) begin
			kw_q <= 3'd0;
		end else if (state_q == HS_KEY) begin
			kw_q <= kw_q + 3'd1;
		end
	end

	// Compare uses data of previous address
	logic [1:0] cmp_idx_q;
	logic       cmp_en_q;
	logic       ok_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_idx_q <= 2'd0;
			cmp_en_q  <= 1'b0;
		end else begin
			cmp_idx_q <= kw_q[1:0];
			cmp_en_q  <= (state_q == HS_KEY) && (kw_q != 3'd4);
		end
	end
	assign ok_d = key_rdata_q == hash_q[255 - 64*cmp_idx_q -: 64];

	logic match_r_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_r_q <= 1'b1;
		end else if (start) begin
			match_r_q <= 1'b1;
		end else if (cmp_en_q && !ok_d) begin
			match_r_q <= 1'b0;
		end
	end

	// Verdict tracking and output register
	logic fail;
	assign fail = !match_r_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_q       <= 1'b1;
			mis_q       <= 8'd0;
			out_valid_q <= 1'b0;
			out_verdict_q <= 1'b0;
			out_index_q <= 8'd0;
		end else begin
			if (fin && elem_q == LAST_ELEMENT) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
			if (fin) begin
				if (elem_q == LAST_ELEMENT) begin
					if (fail && (all_q || elem_q < mis_q)) begin
						out_verdict_q <= 1'b0;
						out_index_q   <= elem_q;
					end else begin
						out_verdict_q <= all_q;
						out_index_q   <= all_q ? 8'd0 : mis_q;
					end
					all_q <= 1'b1;
					mis_q <= 8'd0;
				end else if (fail && (all_q || elem_q < mis_q)) begin
					all_q <= 1'b0;
					mis_q <= elem_q;
				end
			end
		end
	end

	assign res_valid   = out_valid_q;
	assign res_verdict = out_verdict_q;
	assign res_index   = out_index_q;
endmodule
